>>> design/dfl_bed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfl_bed_pkg: shared types and constants for the box edge decoder
// Word formats of both channels, controller/datapath command and status
// groups, and the constant function that builds the exp lookup table.
// ----------------------------------------------------------------------------
package dfl_bed_pkg;

    // default configuration
    localparam int BINS_DEF      = 16;
    localparam int EXP_DEPTH_DEF = 256;

    // accumulator widths
    localparam int WSUM_W = 24;
    localparam int ISUM_W = 28;

    // input word: one bin logit plus the cell it belongs to
    typedef struct packed {
        logic signed [15:0] bin_logit;
        logic [1:0]         edge_side;
        logic [7:0]         cell_col;
        logic [7:0]         cell_row;
        logic [2:0]         stride_log2;
    } in_word_t;

    // result word: one decoded edge coordinate
    typedef struct packed {
        logic [1:0]         out_side;
        logic signed [15:0] edge_coord;
        logic               coord_saturated;
    } out_word_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // bin word accepted this cycle
        logic first;      // accepted bin opens an edge
        logic acc_clear;  // clear the weight sums
        logic issue;      // read one stored bin into the weight pipe
        logic div_init;   // set up the quotient from the sums
        logic div_step;   // one restoring division step
        logic out_load;   // build the result word
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic pipe_busy;  // weight pipe still holds bins
        logic out_free;   // result register can take a word
    } status_t;

    // exp(-32r) in Q0.16, r given in Q0.32 as a thirty-second of the table argument;
    // Taylor series to the 12th term then squared five times
    function automatic logic [15:0] exp_entry(input logic [63:0] r);
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        logic [63:0]        q;
        term = 64'd1 << 32;
        sum  = $signed(term);
        for (int k = 1; k <= 12; k++) begin
            term = ((term * r) >> 32) / 64'(k);
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = $unsigned(sum);
        for (int k = 0; k < 5; k++) begin
            if (v > 64'hFFFF_FFFF) begin
                v = 64'hFFFF_FFFF;
            end
            v = (v * v) >> 32;
        end
        q = (v + 64'h8000) >> 16;
        if (q > 64'd65535) begin
            q = 64'd65535;
        end
        return q[15:0];
    endfunction

endpackage
`default_nettype wire

>>> design/dfl_box_edge_decode.sv
`default_nettype none
// From the last bin word of an edge to its result word: one weight per cycle,
//   a drain of the weight pipe, then one quotient bit per cycle in the divider.
// Bin words are taken only while the block is loading, so a new edge waits until
//   the previous result word has gone into the result register.
// Reset: synchronous active-low aresetn clears control and sums, not the bin store.
// ----------------------------------------------------------------------------
// dfl_box_edge_decode: distribution decode of one bounding box edge
// Collects the bin logits of an edge, forms the softmax-weighted mean bin
// and emits the edge coordinate in Q12.4 pixels.
// ----------------------------------------------------------------------------
module dfl_box_edge_decode #(
    parameter int BINS            = dfl_bed_pkg::BINS_DEF,
    parameter int EXP_TABLE_DEPTH = dfl_bed_pkg::EXP_DEPTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output      logic                    s_ready,
    input  wire dfl_bed_pkg::in_word_t   s_data,
    output      logic                    m_valid,
    input  wire logic                    m_ready,
    output      dfl_bed_pkg::out_word_t  m_data
);
    import dfl_bed_pkg::*;

    cmd_t                     cmd;
    status_t                  status;
    logic [$clog2(BINS)-1:0]  bin_addr;

    // sequencer
    dfl_bed_ctrl #(
        .BINS(BINS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd),
        .bin_addr (bin_addr)
    );

    // datapath
    dfl_bed_dp #(
        .BINS            (BINS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .bin_addr (bin_addr),
        .s_data   (s_data),
        .status   (status),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // no bin word is taken while the divider runs
    a_no_load_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_ready)
        else $error("bin word accepted during division");

    // a result is built only into a free result register
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result overwrites a pending word");

    // a built result is shown on the next cycle
    a_out_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result word not presented");

    // the divider starts only on a drained weight pipe
    a_div_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_init |-> !status.pipe_busy && !cmd.issue)
        else $error("division started with weights in flight");

endmodule
`default_nettype wire

>>> design/dfl_bed_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfl_bed_ctrl: sequencer of the box edge decoder
// Counts bins in, walks the stored bins through the weight pipe, runs the
// division steps and hands the finished edge to the result register.
// ----------------------------------------------------------------------------
module dfl_bed_ctrl #(
    parameter int BINS = dfl_bed_pkg::BINS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output      logic                     s_ready,
    input  wire dfl_bed_pkg::status_t     status,
    output      dfl_bed_pkg::cmd_t        cmd,
    output      logic [$clog2(BINS)-1:0]  bin_addr
);
    import dfl_bed_pkg::*;

    localparam int AW  = $clog2(BINS);
    localparam int QW  = $clog2(BINS) + 12;
    localparam int DCW = $clog2(QW);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_CALC  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [DCW-1:0]  dcnt_reg, dcnt_next;
    logic            cnt_last;

    assign cnt_last = (cnt_reg == AW'(BINS - 1));
    assign bin_addr = cnt_reg;
    assign s_ready  = (state_reg == ST_LOAD);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dcnt_next  = dcnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    cmd.load  = 1'b1;
                    cmd.first = (cnt_reg == '0);
                    if (cnt_last) begin
                        cmd.acc_clear = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_CALC;
                    end else begin
                        cnt_next = cnt_reg + AW'(1);
                    end
                end
            end
            ST_CALC: begin
                cmd.issue = 1'b1;
                if (cnt_last) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    cmd.div_init = 1'b1;
                    dcnt_next    = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (dcnt_reg == DCW'(QW - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    dcnt_next = dcnt_reg + DCW'(1);
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            dcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dcnt_reg  <= dcnt_next;
        end
    end

endmodule
`default_nettype wire

>>> design/dfl_bed_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfl_bed_dp: datapath of the box edge decoder
// Bin store, running max, exp weight pipe with accumulators, restoring
// divider for the mean distance and the result register.
// ----------------------------------------------------------------------------
module dfl_bed_dp #(
    parameter int BINS            = dfl_bed_pkg::BINS_DEF,
    parameter int EXP_TABLE_DEPTH = dfl_bed_pkg::EXP_DEPTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire dfl_bed_pkg::cmd_t        cmd,
    input  wire logic [$clog2(BINS)-1:0]  bin_addr,
    input  wire dfl_bed_pkg::in_word_t    s_data,
    output      dfl_bed_pkg::status_t     status,
    output      logic                     m_valid,
    input  wire logic                     m_ready,
    output      dfl_bed_pkg::out_word_t   m_data
);
    import dfl_bed_pkg::*;

    localparam int AW  = $clog2(BINS);
    localparam int TW  = $clog2(EXP_TABLE_DEPTH);
    localparam int PW  = 17 + $clog2(EXP_TABLE_DEPTH + 1);
    localparam int QW  = $clog2(BINS) + 12;
    localparam int NW  = ISUM_W + 12;
    localparam int VW  = ((QW > 19) ? QW : 19) + 2;

    // exp table, Q0.16, built at elaboration
    logic [15:0] exp_rom [EXP_TABLE_DEPTH];
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
        localparam logic [63:0] EntryR = (64'(g) << 31) / EXP_TABLE_DEPTH;
        assign exp_rom[g] = exp_entry(EntryR);
    end

    logic [15:0]        store_mem [BINS];
    logic signed [15:0] max_reg;
    logic [1:0]         side_reg;
    logic [7:0]         col_reg;
    logic [7:0]         row_reg;
    logic [2:0]         slog_reg;

    logic               p1_vld_reg, p2_vld_reg;
    logic [15:0]        rd_data_reg;
    logic [AW-1:0]      p1_idx_reg, p2_idx_reg;
    logic [15:0]        w_reg;
    logic [WSUM_W-1:0]  ws_reg;
    logic [ISUM_W-1:0]  iws_reg;

    logic [WSUM_W-1:0]  rem_reg;
    logic [QW-1:0]      quo_reg;

    logic               m_valid_reg;
    out_word_t          m_data_reg;

    logic [16:0]        diff;
    logic [PW-1:0]      tprod;
    logic [PW-1:0]      tshift;
    logic [TW-1:0]      tidx;
    logic [AW+15:0]     iw_prod;
    logic [NW-1:0]      num;
    logic [3:0]         div_sh;
    logic [WSUM_W:0]    rem_try;
    logic               q_bit;

    logic [7:0]         grid;
    logic [18:0]        centre;
    logic [QW-1:0]      mean_dist;
    logic signed [VW-1:0] cen_s, dist_s, val;
    out_word_t          out_next;

    // bin store and read port
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            store_mem[bin_addr] <= s_data.bin_logit;
        end
        rd_data_reg <= store_mem[bin_addr];
    end

    // edge header and running max
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (cmd.first) begin
                side_reg <= s_data.edge_side;
                col_reg  <= s_data.cell_col;
                row_reg  <= s_data.cell_row;
                slog_reg <= s_data.stride_log2;
                max_reg  <= s_data.bin_logit;
            end else if (s_data.bin_logit > max_reg) begin
                max_reg <= s_data.bin_logit;
            end
        end
    end

    // table index from distance below max
    always_comb begin
        diff   = 17'($signed({max_reg[15], max_reg}) -
                     $signed({rd_data_reg[15], rd_data_reg}));
        tprod  = PW'(diff) * PW'(EXP_TABLE_DEPTH);
        tshift = tprod >> 12;
        if (tshift >= PW'(EXP_TABLE_DEPTH - 1)) begin
            tidx = TW'(EXP_TABLE_DEPTH - 1);
        end else begin
            tidx = TW'(tshift);
        end
        iw_prod = (AW + 16)'(p2_idx_reg) * (AW + 16)'(w_reg);
    end

    // weight pipe payload
    always_ff @(posedge aclk) begin
        p1_idx_reg <= bin_addr;
        p2_idx_reg <= p1_idx_reg;
        w_reg      <= exp_rom[tidx];
    end

    // weight pipe valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else begin
            p1_vld_reg <= cmd.issue;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    // weight sums
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.acc_clear) begin
            ws_reg  <= '0;
            iws_reg <= '0;
        end else if (p2_vld_reg) begin
            ws_reg  <= WSUM_W'(ws_reg + WSUM_W'(w_reg));
            iws_reg <= ISUM_W'(iws_reg + ISUM_W'(iw_prod));
        end
    end

    // scaled numerator with half the divisor for rounding
    always_comb begin
        div_sh  = 4'(slog_reg) + 4'd4;
        num     = (NW'(iws_reg) << div_sh) + NW'(ws_reg >> 1);
        rem_try = {rem_reg, quo_reg[QW-1]};
        q_bit   = (rem_try >= {1'b0, ws_reg});
    end

    // restoring divider, one quotient bit a step
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= WSUM_W'(num >> QW);
            quo_reg <= num[QW-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= q_bit ? WSUM_W'(rem_try - {1'b0, ws_reg}) : WSUM_W'(rem_try);
            quo_reg <= {quo_reg[QW-2:0], q_bit};
        end
    end

    // coordinate from cell centre and mean distance
    always_comb begin
        grid      = side_reg[0] ? row_reg : col_reg;
        centre    = 19'({grid, 1'b1}) << (4'(slog_reg) + 4'd3);
        mean_dist = (ws_reg == '0) ? '0 : quo_reg;
        cen_s     = $signed(VW'(centre));
        dist_s    = $signed(VW'(mean_dist));
        val       = side_reg[1] ? (cen_s + dist_s) : (cen_s - dist_s);
        out_next.out_side = side_reg;
        if (val > $signed(VW'(32767))) begin
            out_next.edge_coord      = 16'sh7FFF;
            out_next.coord_saturated = 1'b1;
        end else if (val < -$signed(VW'(32768))) begin
            out_next.edge_coord      = 16'sh8000;
            out_next.coord_saturated = 1'b1;
        end else begin
            out_next.edge_coord      = val[15:0];
            out_next.coord_saturated = 1'b0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_data           = m_data_reg;
    assign status.pipe_busy = p1_vld_reg | p2_vld_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule
`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the box edge decoder
// Streams bin words of complete edges through the input channel, predicts the
// decoded edge coordinate of every edge and checks each result word against
// the oldest prediction, under several idle and stall mixes and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import dfl_bed_pkg::*;

    localparam int BINS      = BINS_DEF;
    localparam int EXP_DEPTH = EXP_DEPTH_DEF;
    localparam int LATENCY   = BINS + $clog2(BINS) + 16;

    // edge side codes
    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_TOP    = 2'd1;
    localparam logic [1:0] SIDE_RIGHT  = 2'd2;
    localparam logic [1:0] SIDE_BOTTOM = 2'd3;

    // logit limits in Q8.8
    localparam logic signed [15:0] LOGIT_MIN = 16'sh8000;
    localparam logic signed [15:0] LOGIT_MAX = 16'sh7FFF;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    dfl_box_edge_decode dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // traffic shaping knobs
    int src_idle_pct;
    int sink_stall_pct;
    int hold_len;
    int hold_seq;

    // bookkeeping
    int errors;
    int words_sent;
    int edges_checked;

    // predicted edge results, oldest first
    out_word_t pending_edges[$];

    // bins of the edge being sent by a test task
    logic signed [15:0] edge_logits [BINS];

    // predictor state
    logic [15:0]        exp_lut [EXP_DEPTH];
    logic signed [15:0] seen_bins [BINS];
    int                 bins_held;
    logic signed [15:0] peak_logit;
    logic [1:0]         held_side;
    logic [7:0]         held_col;
    logic [7:0]         held_row;
    logic [2:0]         held_slog;

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // exp(-16*i/depth) in Q0.16: series for exp(-x/32), then squared five times
    function automatic logic [15:0] exp_weight(int unsigned i);
        logic [63:0] arg;
        logic [63:0] term;
        logic [63:0] v;
        logic [63:0] q;
        longint      acc;
        arg  = (64'(i) << 31) / 64'(EXP_DEPTH);
        term = 64'd1 << 32;
        acc  = longint'(term);
        for (int k = 1; k <= 12; k++) begin
            term = ((term * arg) >> 32) / 64'(k);
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        v = 64'(acc);
        for (int k = 0; k < 5; k++) begin
            if (v > 64'hFFFF_FFFF) begin
                v = 64'hFFFF_FFFF;
            end
            v = (v * v) >> 32;
        end
        q = (v + 64'h8000) >> 16;
        if (q > 64'd65535) begin
            q = 64'd65535;
        end
        return q[15:0];
    endfunction

    // fold one accepted bin into the prediction, queue the edge when complete
    task automatic absorb_bin(input in_word_t w);
        int          diff;
        int          idx;
        longint unsigned wsum;
        longint unsigned isum;
        longint unsigned num;
        longint      centre;
        longint      mean_dist;
        longint      val;
        logic [7:0]  grid;
        out_word_t   res;
        if (bins_held == 0) begin
            held_side  = w.edge_side;
            held_col   = w.cell_col;
            held_row   = w.cell_row;
            held_slog  = w.stride_log2;
            peak_logit = $signed(w.bin_logit);
        end else if ($signed(w.bin_logit) > peak_logit) begin
            peak_logit = $signed(w.bin_logit);
        end
        seen_bins[bins_held] = $signed(w.bin_logit);
        bins_held++;
        if (bins_held == BINS) begin
            bins_held = 0;
            wsum = 0;
            isum = 0;
            // softmax weights relative to the peak
            for (int b = 0; b < BINS; b++) begin
                diff = int'(peak_logit) - int'(seen_bins[b]);
                idx  = (diff * EXP_DEPTH) >> 12;
                if (idx >= EXP_DEPTH) begin
                    idx = EXP_DEPTH - 1;
                end
                wsum = wsum + exp_lut[idx];
                isum = isum + longint'(b) * exp_lut[idx];
            end
            wsum = wsum & 64'hFF_FFFF;
            isum = isum & 64'hFFF_FFFF;
            // anchor centre and rounded distance in Q12.4
            grid   = held_side[0] ? held_row : held_col;
            centre = (longint'(grid) * 2 + 1) << (int'(held_slog) + 3);
            if (wsum != 0) begin
                num       = (isum << (int'(held_slog) + 4)) + wsum / 2;
                mean_dist = longint'(num / wsum);
            end else begin
                mean_dist = 0;
            end
            val = (held_side >= SIDE_RIGHT) ? centre + mean_dist : centre - mean_dist;
            res.coord_saturated = 1'b0;
            if (val > 32767) begin
                val = 32767;
                res.coord_saturated = 1'b1;
            end else if (val < -32768) begin
                val = -32768;
                res.coord_saturated = 1'b1;
            end
            res.out_side   = held_side;
            res.edge_coord = val[15:0];
            pending_edges = {pending_edges, res};
        end
    endtask

    // offer one bin word after a random idle gap, return once accepted
    task automatic send_word(input in_word_t w);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < src_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        words_sent++;
        absorb_bin(w);
    endtask

    // send the bins in edge_logits as one edge; scramble varies later fields
    task automatic send_edge(input logic [1:0] side, input logic [7:0] col,
                             input logic [7:0] row, input logic [2:0] slog,
                             input bit scramble);
        in_word_t w;
        for (int b = 0; b < BINS; b++) begin
            w.bin_logit   = edge_logits[b];
            w.edge_side   = side;
            w.cell_col    = col;
            w.cell_row    = row;
            w.stride_log2 = slog;
            if (b > 0 && scramble) begin
                w.edge_side   = 2'($urandom);
                w.cell_col    = 8'($urandom);
                w.cell_row    = 8'($urandom);
                w.stride_log2 = 3'($urandom);
            end
            send_word(w);
        end
    endtask

    task automatic fill_bins(input logic signed [15:0] v);
        for (int b = 0; b < BINS; b++) begin
            edge_logits[b] = v;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_edges.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_data);
                errors++;
            end else begin
                want = pending_edges.pop_front();
                edges_checked++;
                if (m_data.out_side !== want.out_side) begin
                    $display("%0t: out_side expected %0d got %0d",
                             $time, want.out_side, m_data.out_side);
                    errors++;
                end
                if (m_data.edge_coord !== want.edge_coord) begin
                    $display("%0t: edge_coord expected %0d got %0d",
                             $time, want.edge_coord, m_data.edge_coord);
                    errors++;
                end
                if (m_data.coord_saturated !== want.coord_saturated) begin
                    $display("%0t: coord_saturated expected %0b got %0b",
                             $time, want.coord_saturated, m_data.coord_saturated);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    initial begin
        int hold_cnt;
        int hold_seen;
        hold_cnt  = 0;
        hold_seen = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_cnt  = hold_len;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // flat and single-peak distributions, field extremes
    task automatic test_flat_and_peaks();
        fill_bins(16'sd0);
        send_edge(SIDE_LEFT, 8'd0, 8'd0, 3'd3, 1'b0);
        fill_bins(LOGIT_MAX);
        send_edge(SIDE_RIGHT, 8'd255, 8'd0, 3'd5, 1'b0);
        fill_bins(LOGIT_MIN);
        edge_logits[0] = LOGIT_MAX;
        send_edge(SIDE_TOP, 8'd0, 8'd255, 3'd4, 1'b0);
        fill_bins(LOGIT_MIN);
        edge_logits[BINS-1] = LOGIT_MAX;
        send_edge(SIDE_BOTTOM, 8'd255, 8'd255, 3'd3, 1'b0);
    endtask

    // bins right at and past the bottom of the exp range
    task automatic test_exp_range_edge();
        fill_bins(16'sd1000);
        edge_logits[1] = 16'sd1000 - 16'sd4096;
        edge_logits[2] = 16'sd1000 - 16'sd4095;
        edge_logits[3] = 16'sd1000 - 16'sd4097;
        edge_logits[4] = 16'sd1000 - 16'sd16;
        edge_logits[5] = 16'sd1000 - 16'sd15;
        edge_logits[9] = LOGIT_MIN;
        send_edge(SIDE_RIGHT, 8'd37, 8'd90, 3'd4, 1'b0);
    endtask

    // side selects column or row and the sign of the offset
    task automatic test_side_select();
        for (int s = 0; s < 4; s++) begin
            for (int b = 0; b < BINS; b++) begin
                edge_logits[b] = 16'(b * 64 - 512);
            end
            send_edge(2'(s), 8'd10, 8'd200, 3'd4, 1'b0);
        end
    endtask

    // strides outside normal use, including saturation
    task automatic test_stride_extremes();
        fill_bins(LOGIT_MIN);
        edge_logits[BINS-1] = 16'sd0;
        send_edge(SIDE_RIGHT, 8'd255, 8'd3, 3'd7, 1'b0);
        send_edge(SIDE_LEFT, 8'd0, 8'd3, 3'd7, 1'b0);
        fill_bins(16'sd256);
        send_edge(SIDE_BOTTOM, 8'd1, 8'd128, 3'd0, 1'b0);
        send_edge(SIDE_TOP, 8'd1, 8'd255, 3'd6, 1'b0);
    endtask

    // side, cell and stride on later bins must not matter
    task automatic test_later_fields_ignored();
        for (int b = 0; b < BINS; b++) begin
            edge_logits[b] = 16'($urandom);
        end
        send_edge(SIDE_TOP, 8'd77, 8'd11, 3'd5, 1'b1);
    endtask

    // receiver holds off while the sender keeps pushing until input stalls
    task automatic test_input_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_len       = 400;
        hold_seq++;
        for (int e = 0; e < 4; e++) begin
            for (int b = 0; b < BINS; b++) begin
                edge_logits[b] = 16'($urandom_range(0, 3000));
            end
            send_edge(2'($urandom), 8'($urandom), 8'($urandom), 3'd4, 1'b0);
        end
    endtask

    // random edges: mostly peaked distributions, some wild ones
    task automatic run_traffic(input int idle_pct, input int stall_pct,
                               input int edges);
        int          base;
        int          spread;
        int          v;
        logic [2:0]  slog;
        bit          wild;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int e = 0; e < edges; e++) begin
            wild   = ($urandom_range(4) == 0);
            base   = $urandom_range(0, 65535) - 32768;
            case ($urandom_range(2))
                0: spread = 256;
                1: spread = 1024;
                default: spread = 6000;
            endcase
            for (int b = 0; b < BINS; b++) begin
                if (wild) begin
                    edge_logits[b] = 16'($urandom);
                end else begin
                    v = base + $urandom_range(0, spread) - spread / 2;
                    if (v > 32767) begin
                        v = 32767;
                    end else if (v < -32768) begin
                        v = -32768;
                    end
                    edge_logits[b] = 16'(v);
                end
            end
            slog = wild ? 3'($urandom) : 3'($urandom_range(3, 5));
            send_edge(2'($urandom), 8'($urandom), 8'($urandom), slog, wild);
        end
    endtask

    // main sequence
    initial begin
        errors         = 0;
        words_sent     = 0;
        edges_checked  = 0;
        bins_held      = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_len       = 0;
        hold_seq       = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            exp_lut[i] = exp_weight(i);
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_flat_and_peaks();
        test_exp_range_edge();
        test_side_select();
        test_stride_extremes();
        test_later_fields_ignored();
        test_input_backpressure();

        run_traffic(0, 0, 3);
        run_traffic(86, 0, 3);
        run_traffic(0, 86, 3);
        run_traffic(30, 30, 3);
        run_traffic(0, 0, 1);

        // drain
        s_valid <= 1'b0;
        sink_stall_pct = 0;
        while (pending_edges.size() != 0) begin
            @(posedge aclk);
        end
        repeat (LATENCY + 8) @(posedge aclk);

        $display("decoded %0d edges from %0d bin words, %0d mismatches",
                 edges_checked, words_sent, errors);
        $display("covered all sides, stride extremes, exp range clamp, hold-off");
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
